// ----- rtl/sialu_pkg.sv -----
// sialu_pkg: operation codes, widths and shared types for the signed ALU.
// No dependencies.
package sialu_pkg;

    localparam int unsigned FIELD_W   = 32;
    localparam int unsigned FUNC_W    = 4;
    localparam int unsigned DEF_WIDTH = 32;

    typedef enum logic [FUNC_W-1:0] {
        OP_NEG  = 4'd0,
        OP_ADD  = 4'd1,
        OP_SUB  = 4'd2,
        OP_MUL  = 4'd3,
        OP_LT   = 4'd4,
        OP_GT   = 4'd5,
        OP_LE   = 4'd6,
        OP_GE   = 4'd7,
        OP_ABS  = 4'd8,
        OP_CMP  = 4'd9,
        OP_DIV  = 4'd10,
        OP_MOD  = 4'd11,
        OP_QUOT = 4'd12,
        OP_REM  = 4'd13,
        OP_U14  = 4'd14,
        OP_U15  = 4'd15
    } t_op;

    // sideband carried alongside a division request
    typedef struct packed {
        logic valid;
        t_op  op;
        logic neg_a;
        logic diff;
        logic zero_b;
    } t_ctl;

endpackage

// ----- rtl/sialu_div.sv -----
// sialu_div: pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on sialu_pkg.
module sialu_div
    import sialu_pkg::*;
#(
    parameter int unsigned WIDTH = DEF_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_num,
    input  logic [WIDTH-1:0] i_den,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_quot,
    output logic [WIDTH-1:0] o_rem
);

    // stage k holds partial remainder, remaining dividend bits / quotient, divisor
    logic [WIDTH:0]   r_vld;
    logic [WIDTH-1:0] r_rem [WIDTH+1];
    logic [WIDTH-1:0] r_qn  [WIDTH+1];
    logic [WIDTH-1:0] r_den [WIDTH+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[WIDTH-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= '0;
        r_qn[0]  <= i_num;
        r_den[0] <= i_den;
    end

    for (genvar k = 0; k < WIDTH; k++) begin : g_stage
        logic [WIDTH:0]   w_sh;
        logic [WIDTH:0]   w_sub;
        always_comb begin
            w_sh  = {r_rem[k], r_qn[k][WIDTH-1]};
            w_sub = w_sh - {1'b0, r_den[k]};
        end
        always_ff @(posedge i_clk) begin
            r_rem[k+1] <= w_sub[WIDTH] ? w_sh[WIDTH-1:0] : w_sub[WIDTH-1:0];
            r_qn[k+1]  <= {r_qn[k][WIDTH-2:0], ~w_sub[WIDTH]};
            r_den[k+1] <= r_den[k];
        end
    end

    assign o_valid = r_vld[WIDTH];
    assign o_quot  = r_qn[WIDTH];
    assign o_rem   = r_rem[WIDTH];

endmodule

// ----- rtl/sialu_fast.sv -----
// sialu_fast: non-division operations, three register stages (multiply split).
// Depends on sialu_pkg.
module sialu_fast
    import sialu_pkg::*;
#(
    parameter int unsigned WIDTH = DEF_WIDTH
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  t_op              i_op,
    output logic [WIDTH-1:0] o_value
);

    localparam int unsigned HW = WIDTH / 2;
    localparam int unsigned LW = WIDTH - HW;

    logic [WIDTH-1:0] r_simple1, r_simple2, r_simple3;
    logic             r_mul1, r_mul2;
    logic [WIDTH-1:0] r_pll, r_plh, r_phl;
    logic [WIDTH-1:0] r_prod;
    logic [WIDTH-1:0] n_simple;
    logic             w_lt, w_eq;

    always_comb begin
        w_eq = (i_a == i_b);
        w_lt = ($signed(i_a) < $signed(i_b));
        n_simple = '0;
        unique case (i_op)
            OP_NEG:  n_simple = '0 - i_a;
            OP_ADD:  n_simple = i_a + i_b;
            OP_SUB:  n_simple = i_a - i_b;
            OP_LT:   n_simple = WIDTH'(w_lt);
            OP_GT:   n_simple = WIDTH'(!w_lt && !w_eq);
            OP_LE:   n_simple = WIDTH'(w_lt || w_eq);
            OP_GE:   n_simple = WIDTH'(!w_lt);
            OP_ABS:  n_simple = i_a[WIDTH-1] ? ('0 - i_a) : i_a;
            OP_CMP:  n_simple = w_eq ? '0 : (w_lt ? WIDTH'(2) : WIDTH'(1));
            default: n_simple = '0;
        endcase
    end

    // stage 1: partial products of the low WIDTH bits
    always_ff @(posedge i_clk) begin
        r_simple1 <= n_simple;
        r_mul1    <= (i_op == OP_MUL);
        r_pll     <= WIDTH'({{HW{1'b0}}, i_a[LW-1:0]} * {{HW{1'b0}}, i_b[LW-1:0]});
        r_plh     <= WIDTH'(i_a[LW-1:0] * i_b[WIDTH-1:LW]);
        r_phl     <= WIDTH'(i_a[WIDTH-1:LW] * i_b[LW-1:0]);
    end

    // stage 2: combine
    always_ff @(posedge i_clk) begin
        r_simple2 <= r_simple1;
        r_mul2    <= r_mul1;
        r_prod    <= r_pll + ((r_plh + r_phl) << LW);
    end

    // stage 3: select
    always_ff @(posedge i_clk) begin
        r_simple3 <= r_mul2 ? r_prod : r_simple2;
    end

    assign o_value = r_simple3;

endmodule

// ----- rtl/signed_integer_alu_floor_div.sv -----
// signed_integer_alu_floor_div: top level of the pipelined signed ALU.
// Depends on sialu_pkg, sialu_fast, sialu_div.
//
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------
// request  | i_start / o_busy   | i_func, i_operand_a, i_operand_b
// result   | o_done (strobe)    | o_value, o_div_by_zero
//
// Every request passes from i_start through the input register, the divider's
// one-bit-per-stage pipeline and the output register to o_done; non-division
// operations are delayed to match the divider path so results leave in request order.
// One request can be taken every cycle; o_busy is held low.
// Reset (i_rst_n low, synchronous) clears r_v0, the divider's valid chain and r_done.
// The receiver cannot stall, so the pipeline never holds.
module signed_integer_alu_floor_div
    import sialu_pkg::*;
#(
    parameter int unsigned WIDTH = DEF_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    output logic                      o_busy,
    input  logic [FUNC_W-1:0]         i_func,
    input  logic signed [FIELD_W-1:0] i_operand_a,
    input  logic signed [FIELD_W-1:0] i_operand_b,
    output logic                      o_done,
    output logic signed [FIELD_W-1:0] o_value,
    output logic                      o_div_by_zero
);

    // fast path 3 stages plus r_fd[0] vs divider WIDTH+1; delay by the gap
    localparam int unsigned GAP = WIDTH + 1 - 4;

    logic             w_acc;
    logic [WIDTH-1:0] w_a, w_b, w_ma, w_mb;
    t_op              w_op;

    // input register stage
    logic             r_v0;
    logic [WIDTH-1:0] r_a0, r_b0;
    t_op              r_op0;

    assign o_busy = 1'b0;
    assign w_acc  = i_start;
    assign w_op   = t_op'(i_func);

    // sign-extend or truncate the 32-bit fields to the datapath width
    if (WIDTH >= FIELD_W) begin : g_ext
        assign w_a = WIDTH'($signed(i_operand_a));
        assign w_b = WIDTH'($signed(i_operand_b));
    end else begin : g_trunc
        assign w_a = i_operand_a[WIDTH-1:0];
        assign w_b = i_operand_b[WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0  <= w_a;
        r_b0  <= w_b;
        r_op0 <= w_op;
    end

    assign w_ma = r_a0[WIDTH-1] ? ('0 - r_a0) : r_a0;
    assign w_mb = r_b0[WIDTH-1] ? ('0 - r_b0) : r_b0;

    // non-division operations
    logic [WIDTH-1:0] w_fast;
    sialu_fast #(.WIDTH(WIDTH)) u_fast (
        .i_clk   (i_clk),
        .i_a     (r_a0),
        .i_b     (r_b0),
        .i_op    (r_op0),
        .o_value (w_fast)
    );

    // divider on magnitudes
    logic             w_dv;
    logic [WIDTH-1:0] w_q, w_r;
    sialu_div #(.WIDTH(WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v0),
        .i_num   (w_ma),
        .i_den   (w_mb),
        .o_valid (w_dv),
        .o_quot  (w_q),
        .o_rem   (w_r)
    );

    // sideband and operand b travel along the divider
    t_ctl             r_ctl [WIDTH+1];
    logic [WIDTH-1:0] r_bd  [WIDTH+1];
    logic [WIDTH-1:0] r_fd  [GAP+1];

    always_ff @(posedge i_clk) begin
        r_ctl[0] <= '{valid: r_v0, op: r_op0, neg_a: r_a0[WIDTH-1],
                      diff: r_a0[WIDTH-1] ^ r_b0[WIDTH-1], zero_b: (r_b0 == '0)};
        r_bd[0]  <= r_b0;
        for (int k = 0; k < WIDTH; k++) begin
            r_ctl[k+1] <= r_ctl[k];
            r_bd[k+1]  <= r_bd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        r_fd[0] <= w_fast;
        for (int k = 0; k < GAP; k++) begin
            r_fd[k+1] <= r_fd[k];
        end
    end

    // sign fix-up: truncating forms, then floor adjustment when signs differ and the remainder is nonzero
    t_ctl             w_c;
    logic [WIDTH-1:0] w_tq, w_tr, n_val;
    logic             n_dz;
    logic             r_done, r_dz;
    logic [WIDTH-1:0] r_val;

    always_comb begin
        w_c   = r_ctl[WIDTH];
        w_tq  = w_c.diff  ? ('0 - w_q) : w_q;
        w_tr  = w_c.neg_a ? ('0 - w_r) : w_r;
        n_val = r_fd[GAP];
        n_dz  = 1'b0;
        if (w_c.op == OP_DIV || w_c.op == OP_MOD || w_c.op == OP_QUOT
            || w_c.op == OP_REM) begin
            if (w_c.zero_b) begin
                n_val = '0;
                n_dz  = 1'b1;
            end else begin
                unique case (w_c.op)
                    OP_QUOT: n_val = w_tq;
                    OP_REM:  n_val = w_tr;
                    OP_DIV:  n_val = (w_c.diff && w_r != '0) ? w_tq - 1'b1 : w_tq;
                    default: n_val = (w_c.diff && w_r != '0) ? w_tr + r_bd[WIDTH] : w_tr;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= w_dv & w_c.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_dz  <= n_dz;
    end

    assign o_done        = r_done;
    assign o_div_by_zero = r_dz;
    // narrow datapath: the result field carries the WIDTH bits, zero above
    if (WIDTH >= FIELD_W) begin : g_out
        assign o_value = r_val[FIELD_W-1:0];
    end else begin : g_out_ext
        assign o_value = FIELD_W'(r_val);
    end

endmodule
